/* sv/lpr_pkg.sv */
// lpr_pkg: shared types and constants of the length-prefixed packet receiver
// used by lpr_ctrl, lpr_dp and length_prefixed_packet_receiver; no dependencies
`default_nettype none

package lpr_pkg;

	// result status codes
	localparam logic [1:0] STAT_DATA  = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_OVFL  = 2'd2;

	// frame type codes
	localparam logic [1:0] TYPE_EVENT = 2'd2;
	localparam int         TYPE_MAX   = 2;

	// byte positions inside a frame
	localparam int POS_LEN_LO  = 0;
	localparam int POS_LEN_HI  = 1;
	localparam int POS_TYPE    = 2;
	localparam int POS_CMD     = 3;
	localparam int POS_EVT_PAD = 4;
	localparam int POS_PAY     = 4;
	localparam int POS_EVT_PAY = 5;

	// length limits
	localparam int MIN_LEN     = 2;
	localparam int MIN_EVT_LEN = 3;
	localparam int HDR_LEN     = 2;
	localparam int HDR_EVT_LEN = 3;

	localparam logic [5:0] MAX_LENGTH_RST = 6'd50;

	// header word: payload count, command byte, frame type
	localparam int HDR_W = 16;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOAD = 3'b010,
		ST_SEND = 3'b100
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic byte_step;
		logic pop_empty;
		logic pop_load;
		logic send_next;
	} ctl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic count_zero;
		logic frame_ovf;
		logic out_last;
	} dp_stat_t;

endpackage

`default_nettype wire

/* sv/lpr_ctrl.sv */
// lpr_ctrl: request sequencing of the packet receiver (idle, header load, send)
// depends on lpr_pkg; drives the handshake and issues commands to lpr_dp
`default_nettype none

module lpr_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire               in_mode,
	input  wire               out_ready,
	input  lpr_pkg::dp_stat_t stat,
	output logic              in_ready,
	output logic              out_valid,
	output lpr_pkg::ctl_cmd_t cmd
);
	import lpr_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   in_acc;
	logic   out_acc;

	// handshake and commands
	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		out_valid     = (state_q == ST_SEND);
		in_acc        = in_valid & in_ready;
		out_acc       = out_ready & out_valid;
		cmd.byte_step = in_acc & ~in_mode;
		cmd.pop_empty = in_acc & in_mode & stat.count_zero;
		cmd.pop_load  = (state_q == ST_LOAD);
		cmd.send_next = out_acc;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (in_mode)
						state_d = stat.count_zero ? ST_SEND : ST_LOAD;
					else if (stat.frame_ovf)
						state_d = ST_SEND;
				end
			end
			ST_LOAD: state_d = ST_SEND;
			ST_SEND: begin
				if (out_acc && stat.out_last)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

`default_nettype wire

/* sv/lpr_dp.sv */
// lpr_dp: frame parser, slot ring with header and payload memories, result register
// depends on lpr_pkg; commanded by lpr_ctrl
`default_nettype none

module lpr_dp #(
	parameter int SLOTS       = 8,
	parameter int MAX_PAYLOAD = 48
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire  [5:0]        cfg_wdata,
	input  wire  [7:0]        rx_byte,
	input  lpr_pkg::ctl_cmd_t cmd,
	output lpr_pkg::dp_stat_t stat,
	output logic [1:0]        out_status,
	output logic [1:0]        out_type,
	output logic [7:0]        out_cmd,
	output logic [5:0]        out_len,
	output logic [5:0]        out_idx,
	output logic [7:0]        out_byte
);
	import lpr_pkg::*;

	localparam int DEPTH = SLOTS * MAX_PAYLOAD;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = $clog2(SLOTS);
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int POS_W = $clog2(MAX_PAYLOAD + 4);

	// memories
	logic [7:0]       pay_mem [DEPTH];
	logic [HDR_W-1:0] hdr_mem [SLOTS];

	// parser state
	logic [POS_W-1:0] pos_q;
	logic [7:0]       len_q;
	logic [1:0]       type_q;
	logic [7:0]       cmd_q;
	logic             broken_q;
	logic             lost_q;
	logic [5:0]       max_len_q;

	// ring state
	logic [SW-1:0]    wr_slot_q;
	logic [SW-1:0]    rd_slot_q;
	logic [AW-1:0]    wr_base_q;
	logic [AW-1:0]    rd_base_q;
	logic [CW-1:0]    count_q;

	// read side
	logic [HDR_W-1:0] hdr_q;
	logic [7:0]       rdata_q;

	// parser decode
	logic             is_evt;
	logic             full;
	logic             len_bad;
	logic             type_bad;
	logic             frame_end;
	logic             frame_ovf;
	logic             pay_wr;
	logic [POS_W-1:0] pay_idx;
	logic [AW-1:0]    waddr;
	logic [7:0]       cmd_now;
	logic [5:0]       n_pay;
	logic             ring_push;
	logic             ring_pop;
	logic             adv;
	logic [5:0]       idx_sel;
	logic [AW-1:0]    raddr;

	always_comb begin
		is_evt    = (type_q == TYPE_EVENT);
		full      = (count_q == CW'(SLOTS));
		len_bad   = (rx_byte != 8'd0) || (len_q < 8'(MIN_LEN))
		            || (len_q > {2'b00, max_len_q}) || (9'(len_q) > 9'(MAX_PAYLOAD + HDR_LEN));
		type_bad  = (rx_byte > 8'(TYPE_MAX))
		            || ((rx_byte == 8'(TYPE_EVENT)) && (len_q < 8'(MIN_EVT_LEN)));
		pay_idx   = pos_q - (is_evt ? POS_W'(POS_EVT_PAY) : POS_W'(POS_PAY));
		waddr     = wr_base_q + AW'(pay_idx);
		pay_wr    = cmd.byte_step && !broken_q && (pos_q >= POS_W'(POS_PAY))
		            && !(is_evt && (pos_q == POS_W'(POS_EVT_PAD))) && !full;
		frame_end = !broken_q && (pos_q >= POS_W'(POS_CMD))
		            && (9'(pos_q) >= (9'(len_q) + 9'd1));
		frame_ovf = frame_end && (full || lost_q);
		cmd_now   = (pos_q == POS_W'(POS_CMD)) ? rx_byte : cmd_q;
		n_pay     = len_q[5:0] - (is_evt ? 6'(HDR_EVT_LEN) : 6'(HDR_LEN));
		ring_push = cmd.byte_step && frame_end && !frame_ovf;
	end

	// status flags, ring pop, read address for the next payload byte and output byte select
	always_comb begin
		stat.count_zero = (count_q == '0);
		stat.frame_ovf  = frame_ovf;
		stat.out_last   = (out_status != STAT_DATA) || (out_len == 6'd0)
		                  || (out_idx == (out_len - 6'd1));
		ring_pop        = cmd.send_next && stat.out_last && (out_status == STAT_DATA);
		adv             = cmd.send_next && !stat.out_last;
		idx_sel         = adv ? (out_idx + 6'd1) : out_idx;
		raddr           = rd_base_q + AW'(idx_sel);
		out_byte        = ((out_status == STAT_DATA) && (out_len != 6'd0)) ? rdata_q : 8'd0;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_len_q <= MAX_LENGTH_RST;
		else if (cfg_we)
			max_len_q <= cfg_wdata;
	end

	// frame parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			broken_q <= 1'b0;
			lost_q   <= 1'b0;
		end else if (cmd.byte_step) begin
			if (broken_q) begin
				broken_q <= 1'b0;
				pos_q    <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				if (pos_q == POS_W'(POS_LEN_LO))
					lost_q <= 1'b0;
				else if (pos_q == POS_W'(POS_LEN_HI))
					broken_q <= len_bad;
				else if (pos_q == POS_W'(POS_TYPE))
					broken_q <= type_bad;
				else if ((pos_q >= POS_W'(POS_PAY))
				         && !(is_evt && (pos_q == POS_W'(POS_EVT_PAD))) && full)
					lost_q <= 1'b1;
				if (frame_end) begin
					pos_q  <= '0;
					lost_q <= 1'b0;
				end
			end
		end
	end

	// frame fields held while receiving
	always_ff @(posedge clk) begin
		if (cmd.byte_step && !broken_q) begin
			if (pos_q == POS_W'(POS_LEN_LO))
				len_q <= rx_byte;
			if ((pos_q == POS_W'(POS_TYPE)) && !type_bad)
				type_q <= rx_byte[1:0];
			if (pos_q == POS_W'(POS_CMD))
				cmd_q <= rx_byte;
		end
	end

	// slot ring pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q <= '0;
			rd_slot_q <= '0;
			wr_base_q <= '0;
			rd_base_q <= '0;
			count_q   <= '0;
		end else begin
			if (ring_push) begin
				wr_slot_q <= (wr_slot_q == SW'(SLOTS - 1)) ? '0 : wr_slot_q + SW'(1);
				wr_base_q <= (wr_slot_q == SW'(SLOTS - 1)) ? '0 : wr_base_q + AW'(MAX_PAYLOAD);
				count_q   <= count_q + CW'(1);
			end
			if (ring_pop) begin
				rd_slot_q <= (rd_slot_q == SW'(SLOTS - 1)) ? '0 : rd_slot_q + SW'(1);
				rd_base_q <= (rd_slot_q == SW'(SLOTS - 1)) ? '0 : rd_base_q + AW'(MAX_PAYLOAD);
				count_q   <= count_q - CW'(1);
			end
		end
	end

	// payload memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (pay_wr)
			pay_mem[waddr] <= rx_byte;
		rdata_q <= pay_mem[raddr];
	end

	// header memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (ring_push)
			hdr_mem[wr_slot_q] <= {type_q, cmd_now, n_pay};
		hdr_q <= hdr_mem[rd_slot_q];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_status <= STAT_DATA;
			out_type   <= 2'd0;
			out_cmd    <= 8'd0;
			out_len    <= 6'd0;
			out_idx    <= 6'd0;
		end else if (cmd.pop_empty) begin
			out_status <= STAT_EMPTY;
			out_type   <= 2'd0;
			out_cmd    <= 8'd0;
			out_len    <= 6'd0;
			out_idx    <= 6'd0;
		end else if (cmd.byte_step && frame_ovf) begin
			out_status <= STAT_OVFL;
			out_type   <= type_q;
			out_cmd    <= cmd_now;
			out_len    <= n_pay;
			out_idx    <= 6'd0;
		end else if (cmd.pop_load) begin
			out_status <= STAT_DATA;
			out_type   <= hdr_q[15:14];
			out_cmd    <= hdr_q[13:6];
			out_len    <= hdr_q[5:0];
			out_idx    <= 6'd0;
		end else if (cmd.send_next) begin
			out_idx <= stat.out_last ? 6'd0 : out_idx + 6'd1;
		end
	end

endmodule

`default_nettype wire

/* sv/length_prefixed_packet_receiver.sv */
// length_prefixed_packet_receiver: top level, joins lpr_ctrl and lpr_dp
// depends on lpr_pkg, lpr_ctrl, lpr_dp
//
// usage:
//  s_* channel takes one request at a time: s_tuser = 0 delivers a received
//    byte in s_tdata[7:0], s_tuser = 1 pops the oldest stored frame
//  m_* channel returns results; m_tuser is the status (data, empty, overflow),
//    m_tlast marks the final result of a request
//  received bytes give no result, except a completed frame that finds the ring
//    full, which gives one overflow result in the next cycle
//  an empty pop gives one result in the next cycle; a pop of a stored frame
//    loads its header from the header memory in the load state, then streams one payload
//    byte per cycle (registered payload memory read) while m_tready stays high
//  s_tready is low from an accepted request until its last result is taken;
//    a stalled m_tready holds the result and stalls new requests
//  cfg_we writes max_length from cfg_wdata; write only while idle
//  reset clears the ring and parser and sets max_length to 50; the frame
//    memories need no clearing pass
`default_nettype none

module length_prefixed_packet_receiver #(
	parameter int SLOTS       = 8,
	parameter int MAX_PAYLOAD = 48
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [5:0]  cfg_wdata,   // max_length
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,     // [7:0] rx_byte
	input  wire         s_tuser,     // [0] mode
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,     // [1:0] frame_type, [9:2] command_code,
	                                 // [15:10] payload_length, [21:16] byte_index,
	                                 // [29:22] payload_byte, [31:30] zero
	output logic [1:0]  m_tuser,     // [1:0] status
	output logic        m_tlast
);
	import lpr_pkg::*;

	ctl_cmd_t   cmd;
	dp_stat_t   stat;
	logic [1:0] out_status;
	logic [1:0] out_type;
	logic [7:0] out_cmd;
	logic [5:0] out_len;
	logic [5:0] out_idx;
	logic [7:0] out_byte;

	lpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_mode   (s_tuser),
		.out_ready (m_tready),
		.stat      (stat),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.cmd       (cmd)
	);

	lpr_dp #(
		.SLOTS       (SLOTS),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.rx_byte    (s_tdata),
		.cmd        (cmd),
		.stat       (stat),
		.out_status (out_status),
		.out_type   (out_type),
		.out_cmd    (out_cmd),
		.out_len    (out_len),
		.out_idx    (out_idx),
		.out_byte   (out_byte)
	);

	// result packing
	assign m_tdata = {2'b00, out_byte, out_idx, out_len, out_cmd, out_type};
	assign m_tuser = out_status;
	assign m_tlast = stat.out_last;

	// one request in flight: never ready for input while a result is shown
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a result is pending");

	// empty and overflow results are single results
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == STAT_EMPTY || m_tuser == STAT_OVFL)) |-> m_tlast)
		else $error("empty or overflow result not marked last");

	// payload index stays inside the popped frame
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == STAT_DATA && m_tdata[15:10] != 6'd0)
		|-> (m_tdata[21:16] < m_tdata[15:10]))
		else $error("byte index beyond payload length");

	// after the last result of a request the block returns to idle
	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
		else $error("block not idle after last result");

endmodule

`default_nettype wire
